// File: src/skt_pkg.sv
`timescale 1ns / 1ps
// skt_pkg: shared widths and types for the streaming k-th largest core
// no dependencies; imported by skt_cell and streaming_kth_largest_core

package skt_pkg;

  localparam int DATA_W = 32;  // stream value width
  localparam int K_W    = 5;   // k_count register width

  // per-cell control, common to every cell except for the liveness bit
  typedef struct packed {
    logic load;  // request accepted this cycle, cell takes its next value
    logic live;  // cell index is below the current fill count
  } cell_ctl_t;

endpackage

// File: src/skt_cell.sv
`timescale 1ns / 1ps
// skt_cell: one slot of the descending sorted insertion chain
// depends on skt_pkg

module skt_cell (
  input  logic                              clk,
  input  skt_pkg::cell_ctl_t                ctl,
  input  logic signed [skt_pkg::DATA_W-1:0] in_value,
  input  logic signed [skt_pkg::DATA_W-1:0] left_value,
  input  logic                              left_ge,
  output logic                              ge,
  output logic signed [skt_pkg::DATA_W-1:0] val_nxt,
  output logic signed [skt_pkg::DATA_W-1:0] val_r
);
  import skt_pkg::*;

  // entry stays in place when it is live and not below the new value
  assign ge = ctl.live && (val_r >= in_value);

  // first slot that loses the compare takes the new value, later ones shift down
  assign val_nxt = ge ? val_r : (left_ge ? in_value : left_value);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val_r <= val_nxt;
    end
  end

endmodule

// File: src/streaming_kth_largest_core.sv
`timescale 1ns / 1ps
// streaming_kth_largest_core: top level of the streaming k-th largest block
// depends on skt_pkg and skt_cell

// Keeps the k largest signed 32-bit values of the current stream, duplicates
// included, in a chain of MAX_K cells sorted largest first. Every cell compares
// its entry against the incoming value in parallel; the first cell that loses
// takes the new value and the cells behind it take their left neighbor's entry,
// so one value is inserted per clock cycle while not stalled, and the entry that
// falls off the end of the effective k is dropped. Once k entries are held each
// request yields one result, the smallest kept entry (the k-th largest so far);
// before that a request yields nothing. A request with last_in_stream set empties
// the store after its result. k is written through the cfg port; the user must
// do so only while the block is idle, not enforced by the block; 0 acts as 1 and
// values above MAX_K act as MAX_K. Throughput is one request per cycle while not
// stalled, limited by the single-pass compare across the cell chain; the result
// appears in the cycle after the request, through the output register. There is
// no clearing pass after reset: the fill count alone marks which cells hold data.

module streaming_kth_largest_core #(
  parameter int MAX_K = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input requests
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [skt_pkg::DATA_W-1:0] in_value,
  input  logic                              in_last_in_stream,
  // results
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [skt_pkg::DATA_W-1:0] out_kth_largest,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [skt_pkg::K_W-1:0]           cfg_k_count
);
  import skt_pkg::*;

  // count width holds 0..MAX_K, index width addresses the cells
  localparam int KW    = $clog2(MAX_K + 1);
  localparam int IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CMP_W = (KW > K_W) ? KW : K_W;

  logic [K_W-1:0]    k_count_r;
  logic [KW-1:0]     kept_count_r;
  logic [KW-1:0]     kept_count_nxt;
  logic              out_valid_r;
  logic signed [DATA_W-1:0] out_kth_r;

  logic              in_fire;
  logic [CMP_W-1:0]  k_ext;
  logic [CMP_W-1:0]  keff_wide;
  logic [KW-1:0]     keff;
  logic [KW:0]       held_inc;
  logic [KW-1:0]     new_count;
  logic [IDX_W-1:0]  sel_idx;
  logic              produce;

  logic [MAX_K-1:0]         cell_ge;
  logic signed [DATA_W-1:0] cell_val   [MAX_K];
  logic signed [DATA_W-1:0] cell_nxt   [MAX_K];

  // config write is always taken; only legal while idle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_count_r <= K_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      k_count_r <= cfg_k_count;
    end
  end

  // effective k: zero reads as one, saturate at chain length
  assign k_ext     = CMP_W'(k_count_r);
  assign keff_wide = (k_ext == '0) ? CMP_W'(1) :
                     ((k_ext > CMP_W'(MAX_K)) ? CMP_W'(MAX_K) : k_ext);
  assign keff      = keff_wide[KW-1:0];

  // output register frees the input side whenever the result is drained
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // fill count after insertion, clipped to k (also trims after k shrinks)
  assign held_inc  = {1'b0, kept_count_r} + (KW + 1)'(1);
  assign new_count = (held_inc > {1'b0, keff}) ? keff : held_inc[KW-1:0];
  assign produce   = (new_count == keff);
  assign sel_idx   = IDX_W'(keff - KW'(1));

  // sorted insertion chain
  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    cell_ctl_t ctl;
    logic      left_ge;
    logic signed [DATA_W-1:0] left_value;

    assign ctl.load = in_fire;
    assign ctl.live = (KW'(i) < kept_count_r);

    if (i == 0) begin : g_head
      // nothing sits left of the head cell, so it takes the value if it loses
      assign left_ge    = 1'b1;
      assign left_value = in_value;
    end else begin : g_body
      assign left_ge    = cell_ge[i-1];
      assign left_value = cell_val[i-1];
    end

    skt_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .in_value   (in_value),
      .left_value (left_value),
      .left_ge    (left_ge),
      .ge         (cell_ge[i]),
      .val_nxt    (cell_nxt[i]),
      .val_r      (cell_val[i])
    );
  end

  // last_in_stream empties the store after its result
  assign kept_count_nxt = in_last_in_stream ? '0 : new_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_count_r <= '0;
    end else if (in_fire) begin
      kept_count_r <= kept_count_nxt;
    end
  end

  // result register: smallest kept entry after this insertion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= produce;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && produce) begin
      out_kth_r <= cell_nxt[sel_idx];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kth_largest = out_kth_r;

endmodule

// File: src/skt_checker.sv
`timescale 1ns / 1ps
// skt_checker: port-level assertions for streaming_kth_largest_core
// bound to the top level below; no package dependency

module skt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_kth_largest
);

  // a pending result holds with its payload until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kth_largest))
    else $error("result dropped or changed while stalled");

  // reset leaves no result pending
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // an empty output stage never blocks requests
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  // a stalled result stalls the input side
  a_ready_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

  // every new result comes from an accepted request
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without a request");

endmodule

bind streaming_kth_largest_core skt_checker u_skt_checker (.*);
